FILE: hdl/assert_macros.svh
// assertion macros shared by the rtl
// no dependencies; define SYNTHESIS to compile the checks out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: hdl/wo_pkg.sv
// wavetable oscillator package: sizes, codes and request structs
// no dependencies; used by the interfaces and every module but wo_ram
package wo_pkg;

  // table geometry (TABLE_LENGTH must be a power of two)
  localparam int TABLE_LENGTH  = 1024;
  localparam int TABLE_COUNT   = 16;
  localparam int FRACTION_BITS = 16;

  // fixed field widths
  localparam int SAMPLE_W = 16;
  localparam int ADDR_W   = 14;
  localparam int STEP_W   = 26;
  localparam int SEL_W    = 4;
  localparam int REG_W    = 2;
  localparam int CFG_W    = 26;

  // derived sizes
  localparam int ENTRY_W     = $clog2(TABLE_LENGTH);
  localparam int TABLE_W     = (TABLE_COUNT > 1) ? $clog2(TABLE_COUNT) : 1;
  localparam int PHASE_W     = ENTRY_W + FRACTION_BITS;
  localparam int STORE_DEPTH = TABLE_COUNT * TABLE_LENGTH;
  localparam int BANK_DEPTH  = STORE_DEPTH / 2;
  localparam int BANK_AW     = $clog2(BANK_DEPTH);
  localparam int PROD_W      = SAMPLE_W + FRACTION_BITS + 2;

  localparam logic [FRACTION_BITS-1:0] FRAC_HALF = FRACTION_BITS'(1 << (FRACTION_BITS - 1));

  typedef enum logic {
    CMD_TICK  = 1'b0,
    CMD_WRITE = 1'b1
  } command_t;

  typedef enum logic [REG_W-1:0] {
    REG_PHASE_STEP   = 2'd0,
    REG_TABLE_SELECT = 2'd1,
    REG_ENABLE       = 2'd2
  } reg_index_t;

  // table word write into the banked store
  typedef struct packed {
    logic                en;
    logic [ADDR_W-1:0]   addr;
    logic [SAMPLE_W-1:0] data;
  } wr_req_t;

  // pair read: entry and its successor within one table
  typedef struct packed {
    logic               en;
    logic [TABLE_W-1:0] tbl;
    logic [ENTRY_W-1:0] entry;
  } rd_req_t;

endpackage

FILE: hdl/wo_if.sv
// channel interfaces of the wavetable oscillator
// depends on wo_pkg for field widths
interface wo_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [wo_pkg::REG_W-1:0]    index;
  logic [wo_pkg::CFG_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

interface wo_in_if;
  logic                              valid;
  logic                              ready;
  logic                              command;
  logic [wo_pkg::ADDR_W-1:0]         table_addr;
  logic signed [wo_pkg::SAMPLE_W-1:0] table_data;
  modport source (output valid, command, table_addr, table_data, input ready);
  modport sink (input valid, command, table_addr, table_data, output ready);
endinterface

interface wo_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [wo_pkg::SAMPLE_W-1:0] sample;
  logic [wo_pkg::SAMPLE_W-1:0]        sample_unipolar;
  modport source (output valid, sample, sample_unipolar, input ready);
  modport sink (input valid, sample, sample_unipolar, output ready);
endinterface

FILE: hdl/wavetable_oscillator.sv
// wavetable oscillator top level: config registers, phase accumulator,
// read stage; depends on wo_pkg, wo_if, wo_store, wo_interp, assert_macros.svh
//
//   channel   dir  transaction     payload
//   cfg       in   register write  index, data
//   items     in   tick or write   command, table_addr, table_data
//   results   out  one per tick    sample, sample_unipolar
//
// one item per cycle sustained while results are taken; a tick result is
// registered through the store read, multiply, and round-and-add stages;
// table writes give no result and use the store write port
// rst clears the phase, the registers and the pipeline valids; the table
// store keeps whatever it held and must be loaded before it is played
// a stalled results channel backs up through the pipeline stage by stage;
// cfg is always ready
`include "assert_macros.svh"

module wavetable_oscillator (
  input  logic      clk,
  input  logic      rst,
  wo_cfg_if.sink    cfg,
  wo_in_if.sink     items,
  wo_out_if.source  results
);

  // configuration registers
  logic [wo_pkg::STEP_W-1:0]        phase_step;
  logic [wo_pkg::SEL_W-1:0]         table_select;
  logic                             enable;

  // phase accumulator, wraps at the table length by width alone
  logic [wo_pkg::PHASE_W-1:0]       phase;
  logic [wo_pkg::PHASE_W-1:0]       phase_next;

  // read stage: store data arrive here in the cycle after the read
  logic                             s1_valid;
  logic                             s1_play;
  logic [wo_pkg::FRACTION_BITS-1:0] s1_frac;

  logic                             s1_ready;
  logic                             interp_ready;
  logic                             tick_acc;
  logic                             sel_ok;
  logic                             play;
  logic signed [wo_pkg::SAMPLE_W-1:0] word_a;
  logic signed [wo_pkg::SAMPLE_W-1:0] word_b;
  wo_pkg::wr_req_t                  wr;
  wo_pkg::rd_req_t                  rd;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step   <= '0;
      table_select <= '0;
      enable       <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        wo_pkg::REG_PHASE_STEP:   phase_step   <= wo_pkg::STEP_W'(cfg.data);
        wo_pkg::REG_TABLE_SELECT: table_select <= wo_pkg::SEL_W'(cfg.data);
        wo_pkg::REG_ENABLE:       enable       <= cfg.data[0];
        default: begin
          // writes beyond the register list are dropped
        end
      endcase
    end
  end

  // the item side only waits when the read stage holds a stalled tick
  assign s1_ready    = !s1_valid || interp_ready;
  assign items.ready = s1_ready;
  assign tick_acc    = items.valid && s1_ready && (items.command == wo_pkg::CMD_TICK);

  // a select past the loaded tables plays silence but still advances
  assign sel_ok     = 32'(table_select) < 32'(wo_pkg::TABLE_COUNT);
  assign play       = enable && sel_ok;
  assign phase_next = phase + wo_pkg::PHASE_W'(phase_step);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (tick_acc && enable) begin
      phase <= phase_next;
    end
  end

  // writes and reads hit the store at the transaction edge, so a tick right
  // after a write already sees the new word: no forwarding path needed
  always_comb begin
    wr.en    = items.valid && s1_ready && (items.command == wo_pkg::CMD_WRITE);
    wr.addr  = items.table_addr;
    wr.data  = items.table_data;
    rd.en    = tick_acc && play;
    rd.tbl   = wo_pkg::TABLE_W'(table_select);
    rd.entry = phase_next[wo_pkg::PHASE_W-1:wo_pkg::FRACTION_BITS];
  end

  wo_store u_store (
    .clk    (clk),
    .wr     (wr),
    .rd     (rd),
    .word_a (word_a),
    .word_b (word_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= tick_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_acc) begin
      s1_play <= play;
      s1_frac <= phase_next[wo_pkg::FRACTION_BITS-1:0];
    end
  end

  wo_interp u_interp (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s1_valid),
    .in_ready (interp_ready),
    .play     (s1_play),
    .frac     (s1_frac),
    .word_a   (word_a),
    .word_b   (word_b),
    .results  (results)
  );

  // phase only moves on an enabled tick
  `ASSERT_NEXT(a_phase_hold, clk, rst, !(tick_acc && enable), phase == $past(phase))
  // an accepted tick always lands in the read stage
  `ASSERT_NEXT(a_tick_to_s1, clk, rst, tick_acc, s1_valid)
  // one store operation per transaction
  `ASSERT_IMPLY(a_single_op, clk, rst, wr.en, !rd.en)

endmodule

FILE: hdl/wo_ram.sv
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
module wo_ram #(
  parameter int DEPTH = 8192,
  parameter int WIDTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hdl/wo_store.sv
// table store split into even and odd entry banks so that an entry and its
// successor come out in the same cycle; depends on wo_pkg and wo_ram
module wo_store (
  input  logic                            clk,
  input  wo_pkg::wr_req_t                 wr,
  input  wo_pkg::rd_req_t                 rd,
  output logic signed [wo_pkg::SAMPLE_W-1:0] word_a,
  output logic signed [wo_pkg::SAMPLE_W-1:0] word_b
);

  localparam int HALF_W = wo_pkg::ENTRY_W - 1;

  logic                           wr_in_range;
  logic                           wr_even;
  logic                           wr_odd;
  logic [wo_pkg::BANK_AW-1:0]     wr_row;
  logic [HALF_W-1:0]              half;
  logic [HALF_W-1:0]              half_inc;
  logic [wo_pkg::BANK_AW-1:0]     even_row;
  logic [wo_pkg::BANK_AW-1:0]     odd_row;
  logic [wo_pkg::SAMPLE_W-1:0]    even_data;
  logic [wo_pkg::SAMPLE_W-1:0]    odd_data;
  logic                           odd_q;

  // entry parity is the address lsb because table length is even
  always_comb begin
    wr_in_range = 32'(wr.addr) < 32'(wo_pkg::STORE_DEPTH);
    wr_even     = wr.en && wr_in_range && !wr.addr[0];
    wr_odd      = wr.en && wr_in_range && wr.addr[0];
    wr_row      = wo_pkg::BANK_AW'(wr.addr >> 1);
  end

  // odd entry: successor lives in the even bank one row up, wrapping in table
  always_comb begin
    half     = rd.entry[wo_pkg::ENTRY_W-1:1];
    half_inc = half + HALF_W'(1);
    odd_row  = {rd.tbl, half};
    even_row = rd.entry[0] ? {rd.tbl, half_inc} : {rd.tbl, half};
  end

  wo_ram #(
    .DEPTH (wo_pkg::BANK_DEPTH),
    .WIDTH (wo_pkg::SAMPLE_W)
  ) u_even (
    .clk     (clk),
    .wr_en   (wr_even),
    .wr_addr (wr_row),
    .wr_data (wr.data),
    .rd_en   (rd.en),
    .rd_addr (even_row),
    .rd_data (even_data)
  );

  wo_ram #(
    .DEPTH (wo_pkg::BANK_DEPTH),
    .WIDTH (wo_pkg::SAMPLE_W)
  ) u_odd (
    .clk     (clk),
    .wr_en   (wr_odd),
    .wr_addr (wr_row),
    .wr_data (wr.data),
    .rd_en   (rd.en),
    .rd_addr (odd_row),
    .rd_data (odd_data)
  );

  always_ff @(posedge clk) begin
    if (rd.en) begin
      odd_q <= rd.entry[0];
    end
  end

  assign word_a = odd_q ? odd_data : even_data;
  assign word_b = odd_q ? even_data : odd_data;

endmodule

FILE: hdl/wo_interp.sv
// linear interpolation pipeline: multiply stage, round-and-add output stage
// depends on wo_pkg and wo_out_if
module wo_interp (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               play,
  input  logic [wo_pkg::FRACTION_BITS-1:0]   frac,
  input  logic signed [wo_pkg::SAMPLE_W-1:0] word_a,
  input  logic signed [wo_pkg::SAMPLE_W-1:0] word_b,
  wo_out_if.source                           results
);

  logic                                  s2_valid;
  logic signed [wo_pkg::SAMPLE_W-1:0]    s2_a;
  logic signed [wo_pkg::PROD_W-1:0]      s2_prod;
  logic                                  out_valid;
  logic signed [wo_pkg::SAMPLE_W-1:0]    sample;

  logic                                  out_free;
  logic signed [wo_pkg::SAMPLE_W:0]      diff;
  logic signed [wo_pkg::FRACTION_BITS:0] frac_s;
  logic signed [wo_pkg::PROD_W-1:0]      prod;
  logic signed [wo_pkg::PROD_W-1:0]      rounded;
  logic signed [wo_pkg::PROD_W-1:0]      step;
  logic signed [wo_pkg::SAMPLE_W-1:0]    sample_next;

  assign out_free = !out_valid || results.ready;
  assign in_ready = !s2_valid || out_free;

  always_comb begin
    diff   = (wo_pkg::SAMPLE_W + 1)'(word_b) - (wo_pkg::SAMPLE_W + 1)'(word_a);
    frac_s = $signed({1'b0, frac});
    prod   = diff * frac_s;
  end

  // floor shift after adding one half: round half up
  always_comb begin
    rounded     = s2_prod + wo_pkg::PROD_W'(wo_pkg::FRAC_HALF);
    step        = rounded >>> wo_pkg::FRACTION_BITS;
    sample_next = s2_a + step[wo_pkg::SAMPLE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s2_valid <= in_valid;
      end
      if (out_free) begin
        out_valid <= s2_valid;
      end
    end
  end

  // muted ticks carry zero through both stages
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s2_a    <= play ? word_a : '0;
      s2_prod <= play ? prod : '0;
    end
    if (s2_valid && out_free) begin
      sample <= sample_next;
    end
  end

  assign results.valid           = out_valid;
  assign results.sample          = sample;
  assign results.sample_unipolar = {~sample[wo_pkg::SAMPLE_W-1], sample[wo_pkg::SAMPLE_W-2:0]};

endmodule
